### rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the binary PPM stream decoder with crop.
// ----------------------------------------------------------------------------
package psd_pkg;

    // width of image dimensions and of the position counters
    localparam int unsigned DIM_BITS = 16;

    // maxval must stay below 2^MAXVAL_BITS
    localparam int unsigned MAXVAL_BITS = 16;

    // maxval at or above 2^WIDE_SAMPLE_BIT selects two-byte samples
    localparam int unsigned WIDE_SAMPLE_BIT = 8;

    // decimal accumulator, wide enough to flag any oversized number
    localparam int unsigned ACC_BITS =
        ((DIM_BITS > MAXVAL_BITS) ? DIM_BITS : MAXVAL_BITS) + 1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CROP_LEFT   = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CROP_RIGHT  = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CROP_TOP    = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CROP_BOTTOM = 8'd3;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SIG    = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [2:0] ST_EOF_HEADER = 3'd3;
    localparam logic [2:0] ST_DELIM_WARN = 3'd4;
    localparam logic [2:0] ST_TRUNCATED  = 3'd5;

    // crop window registers
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] bottom;
    } crop_t;

    // one input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] col;
        logic [15:0] row;
        logic [2:0]  status;
        logic        last_of_image;
    } out_item_t;

endpackage

### rtl/psd_cfg.sv
// ----------------------------------------------------------------------------
// psd_cfg
// Crop window register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module psd_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [15:0]                        cfg_data,
    output psd_pkg::crop_t                     crop
);
    import psd_pkg::*;

    crop_t crop_reg;
    crop_t crop_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign crop      = crop_reg;

    // decode the register index, unknown indexes are dropped
    always_comb
    begin
        crop_next = crop_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CROP_LEFT:   crop_next.left   = cfg_data;
                CFG_CROP_RIGHT:  crop_next.right  = cfg_data;
                CFG_CROP_TOP:    crop_next.top    = cfg_data;
                CFG_CROP_BOTTOM: crop_next.bottom = cfg_data;
                default:         crop_next        = crop_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crop_reg <= '0;
        end
        else
        begin
            crop_reg <= crop_next;
        end
    end

endmodule

### rtl/psd_core.sv
// ----------------------------------------------------------------------------
// psd_core
// Parser state and decode of one byte per cycle while input is accepted:
// signature, header numbers, delimiter, pixel assembly and crop window test.
// ----------------------------------------------------------------------------
module psd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  psd_pkg::in_item_t  in_data,
    input  psd_pkg::crop_t     crop,
    output logic               res_valid,
    output psd_pkg::out_item_t res_data
);
    import psd_pkg::*;

    localparam int unsigned CW = ACC_BITS;

    localparam logic [1:0] NUM_WIDTH  = 2'd0;
    localparam logic [1:0] NUM_HEIGHT = 2'd1;
    localparam logic [1:0] NUM_MAXVAL = 2'd2;

    localparam logic [7:0] CHAR_P = 8'h50;
    localparam logic [7:0] CHAR_6 = 8'h36;

    localparam logic [2:0] LAST_BYTE_NARROW = 3'd2;
    localparam logic [2:0] LAST_BYTE_WIDE   = 3'd5;

    localparam logic [ACC_BITS-1:0] ACC_ONE = {{(ACC_BITS-1){1'b0}}, 1'b1};
    localparam logic [ACC_BITS-1:0] ACC_CAP = {1'b1, {(ACC_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        PH_SIG0   = 4'd0,
        PH_SIG1   = 4'd1,
        PH_SKIP_W = 4'd2,
        PH_NUM_W  = 4'd3,
        PH_SKIP_H = 4'd4,
        PH_NUM_H  = 4'd5,
        PH_SKIP_M = 4'd6,
        PH_NUM_M  = 4'd7,
        PH_DELIM  = 4'd8,
        PH_PIX    = 4'd9,
        PH_HALT   = 4'd10
    } phase_t;

    phase_t                phase_reg,    phase_next;
    logic [ACC_BITS-1:0]   acc_reg,      acc_next;
    logic [DIM_BITS-1:0]   width_reg,    width_next;
    logic [DIM_BITS-1:0]   height_reg,   height_next;
    logic                  two_byte_reg, two_byte_next;
    logic [2:0]            bip_reg,      bip_next;
    logic [39:0]           partial_reg,  partial_next;
    logic [DIM_BITS-1:0]   col_reg,      col_next;
    logic [DIM_BITS-1:0]   row_reg,      row_next;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // a - (b + c), floored at zero
    function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b,
                                              input logic [CW-1:0] c);
        logic [CW-1:0] s;
        s = b + c;
        return (s >= a) ? '0 : (a - s);
    endfunction

    logic [7:0] b;
    logic       eof;
    logic       b_ws;
    logic       b_digit;

    assign b       = in_data.in_byte;
    assign eof     = in_data.end_of_stream;
    assign b_ws    = is_ws(b);
    assign b_digit = is_digit(b);

    // header item decode from the phase
    logic [1:0] hdr_k;
    logic       hdr_in_num;
    phase_t     hdr_num_phase;
    phase_t     hdr_skip_after;

    always_comb
    begin
        hdr_k          = NUM_WIDTH;
        hdr_in_num     = 1'b0;
        hdr_num_phase  = PH_NUM_W;
        hdr_skip_after = PH_SKIP_H;
        case (phase_reg)
            PH_NUM_W:
            begin
                hdr_in_num = 1'b1;
            end
            PH_SKIP_H, PH_NUM_H:
            begin
                hdr_k          = NUM_HEIGHT;
                hdr_in_num     = (phase_reg == PH_NUM_H);
                hdr_num_phase  = PH_NUM_H;
                hdr_skip_after = PH_SKIP_M;
            end
            PH_SKIP_M, PH_NUM_M:
            begin
                hdr_k          = NUM_MAXVAL;
                hdr_in_num     = (phase_reg == PH_NUM_M);
                hdr_num_phase  = PH_NUM_M;
                hdr_skip_after = PH_DELIM;
            end
            default:
            begin
                hdr_k = NUM_WIDTH;
            end
        endcase
    end

    // decimal accumulate with saturation
    logic [ACC_BITS-1:0] acc_base;
    logic [ACC_BITS+3:0] acc_mul;
    logic [ACC_BITS-1:0] acc_sat;

    assign acc_base = hdr_in_num ? acc_reg : '0;
    assign acc_mul  = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
                    + {{ACC_BITS{1'b0}}, b[3:0]};
    assign acc_sat  = (acc_mul > {4'b0, ACC_CAP}) ? ACC_CAP : acc_mul[ACC_BITS-1:0];

    // range check of the number that ends here
    logic                 hdr_too_big;
    logic [DIM_BITS-1:0]  hdr_dim;
    logic                 hdr_wide;

    assign hdr_dim     = acc_base[DIM_BITS-1:0];
    assign hdr_wide    = |acc_base[MAXVAL_BITS-1:WIDE_SAMPLE_BIT];
    assign hdr_too_big = (hdr_k == NUM_MAXVAL) ? (|acc_base[ACC_BITS-1:MAXVAL_BITS])
                                               : (|acc_base[ACC_BITS-1:DIM_BITS]);

    // pixel position against the crop window
    logic [CW-1:0] x_ext, y_ext, w_ext, h_ext;
    logic [CW-1:0] cl_ext, cr_ext, ct_ext, cb_ext;
    logic [CW-1:0] x_right, y_bottom;
    logic          pix_inside;
    logic          pix_last;
    logic [DIM_BITS:0] col_plus;
    logic [DIM_BITS:0] row_plus;
    logic [47:0]   pix_full;
    logic          pix_done;

    assign x_ext    = {{(CW-DIM_BITS){1'b0}}, col_reg};
    assign y_ext    = {{(CW-DIM_BITS){1'b0}}, row_reg};
    assign w_ext    = {{(CW-DIM_BITS){1'b0}}, width_reg};
    assign h_ext    = {{(CW-DIM_BITS){1'b0}}, height_reg};
    assign cl_ext   = {{(CW-16){1'b0}}, crop.left};
    assign cr_ext   = {{(CW-16){1'b0}}, crop.right};
    assign ct_ext   = {{(CW-16){1'b0}}, crop.top};
    assign cb_ext   = {{(CW-16){1'b0}}, crop.bottom};
    assign x_right  = x_ext + cr_ext;
    assign y_bottom = y_ext + cb_ext;

    assign pix_inside = (x_ext >= cl_ext) && (x_right < w_ext)
                     && (y_ext >= ct_ext) && (y_bottom < h_ext);
    assign pix_last   = pix_inside && ((x_right + ACC_ONE) == w_ext)
                     && ((y_bottom + ACC_ONE) == h_ext);
    assign col_plus   = {1'b0, col_reg} + {{DIM_BITS{1'b0}}, 1'b1};
    assign row_plus   = {1'b0, row_reg} + {{DIM_BITS{1'b0}}, 1'b1};
    assign pix_full   = {partial_reg, b};
    assign pix_done   = two_byte_reg ? (bip_reg >= LAST_BYTE_WIDE)
                                     : (bip_reg >= LAST_BYTE_NARROW);

    // next state and result for the byte at the input
    logic                 do_delim;
    logic                 fail_en;
    logic [2:0]           fail_code;
    logic                 res_flag;
    out_item_t            res;
    logic [DIM_BITS-1:0]  w_eff, h_eff;
    logic [CW-1:0]        hdr_cols, hdr_rows;

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        two_byte_next = two_byte_reg;
        bip_next      = bip_reg;
        partial_next  = partial_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        do_delim      = 1'b0;
        fail_en       = 1'b0;
        fail_code     = ST_OK;
        res_flag      = 1'b0;
        res           = '0;
        w_eff         = width_reg;
        h_eff         = height_reg;
        hdr_cols      = '0;
        hdr_rows      = '0;

        case (phase_reg)
            PH_HALT:
            begin
                phase_next = PH_HALT;
            end

            // first signature byte, remembered in the accumulator
            PH_SIG0:
            begin
                if (eof)
                begin
                    fail_en   = 1'b1;
                    fail_code = ST_BAD_SIG;
                end
                else
                begin
                    acc_next   = (b == CHAR_P) ? ACC_ONE : '0;
                    phase_next = PH_SIG1;
                end
            end

            PH_SIG1:
            begin
                if (eof || acc_reg != ACC_ONE || b != CHAR_6)
                begin
                    fail_en   = 1'b1;
                    fail_code = ST_BAD_SIG;
                end
                else
                begin
                    acc_next   = '0;
                    phase_next = PH_SKIP_W;
                end
            end

            // header numbers with leading whitespace
            PH_SKIP_W, PH_NUM_W, PH_SKIP_H, PH_NUM_H, PH_SKIP_M, PH_NUM_M:
            begin
                if (!eof && b_digit)
                begin
                    acc_next   = acc_sat;
                    phase_next = hdr_num_phase;
                end
                else if (!eof && !hdr_in_num && b_ws)
                begin
                    phase_next = phase_reg;
                end
                else
                begin
                    acc_next = '0;
                    if (hdr_too_big)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ST_TOO_LARGE;
                    end
                    else if (!eof && b_ws && hdr_k != NUM_MAXVAL)
                    begin
                        // number ends on whitespace, next item starts skipping
                        if (hdr_k == NUM_WIDTH)
                        begin
                            width_next = hdr_dim;
                        end
                        else
                        begin
                            height_next = hdr_dim;
                        end
                        phase_next = hdr_skip_after;
                    end
                    else
                    begin
                        // the same byte closes every later item as empty
                        case (hdr_k)
                            NUM_WIDTH:
                            begin
                                width_next    = hdr_dim;
                                height_next   = '0;
                                two_byte_next = 1'b0;
                            end
                            NUM_HEIGHT:
                            begin
                                height_next   = hdr_dim;
                                two_byte_next = 1'b0;
                            end
                            default:
                            begin
                                two_byte_next = hdr_wide;
                            end
                        endcase
                        w_eff    = width_next;
                        h_eff    = height_next;
                        do_delim = 1'b1;
                    end
                end
            end

            PH_DELIM:
            begin
                do_delim = 1'b1;
            end

            // pixel data, unused codes behave the same
            default:
            begin
                phase_next = PH_PIX;
                if (eof)
                begin
                    fail_en   = 1'b1;
                    fail_code = ST_TRUNCATED;
                end
                else if (!pix_done)
                begin
                    partial_next = {partial_reg[31:0], b};
                    bip_next     = bip_reg + 3'd1;
                end
                else
                begin
                    partial_next = '0;
                    bip_next     = '0;
                    if (col_plus >= {1'b0, width_reg})
                    begin
                        col_next = '0;
                        row_next = row_plus[DIM_BITS-1:0];
                        if (row_plus >= {1'b0, height_reg})
                        begin
                            phase_next = PH_HALT;
                        end
                    end
                    else
                    begin
                        col_next = col_plus[DIM_BITS-1:0];
                    end
                    if (pix_inside)
                    begin
                        res_flag          = 1'b1;
                        res.result_kind   = KIND_PIXEL;
                        if (two_byte_reg)
                        begin
                            res.red   = pix_full[47:32];
                            res.green = pix_full[31:16];
                            res.blue  = pix_full[15:0];
                        end
                        else
                        begin
                            res.red   = {8'h00, pix_full[23:16]};
                            res.green = {8'h00, pix_full[15:8]};
                            res.blue  = {8'h00, pix_full[7:0]};
                        end
                        res.col           = 16'(x_ext - cl_ext);
                        res.row           = 16'(y_ext - ct_ext);
                        res.status        = ST_OK;
                        res.last_of_image = pix_last;
                    end
                end
            end
        endcase

        // header delimiter: report the cropped size
        if (do_delim)
        begin
            if (eof)
            begin
                fail_en   = 1'b1;
                fail_code = ST_EOF_HEADER;
            end
            else
            begin
                hdr_cols        = sat_sub({{(CW-DIM_BITS){1'b0}}, w_eff}, cl_ext, cr_ext);
                hdr_rows        = sat_sub({{(CW-DIM_BITS){1'b0}}, h_eff}, ct_ext, cb_ext);
                col_next        = '0;
                row_next        = '0;
                bip_next        = '0;
                partial_next    = '0;
                phase_next      = (w_eff == '0 || h_eff == '0) ? PH_HALT : PH_PIX;
                res_flag        = 1'b1;
                res.result_kind = KIND_HEADER;
                res.col         = hdr_cols[15:0];
                res.row         = hdr_rows[15:0];
                res.status      = b_ws ? ST_OK : ST_DELIM_WARN;
            end
        end

        // error report, decoding stops until reset
        if (fail_en)
        begin
            phase_next      = PH_HALT;
            res_flag        = 1'b1;
            res             = '0;
            res.result_kind = KIND_STATUS;
            res.status      = fail_code;
        end
    end

    assign res_valid = accept & res_flag;
    assign res_data  = res;

    // parser state, advanced once per input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIG0;
            acc_reg      <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            two_byte_reg <= 1'b0;
            bip_reg      <= '0;
            partial_reg  <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            two_byte_reg <= two_byte_next;
            bip_reg      <= bip_next;
            partial_reg  <= partial_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

endmodule

### rtl/psd_out_buf.sv
// ----------------------------------------------------------------------------
// psd_out_buf
// Two-slot result buffer between the decoder and the result channel.
// ----------------------------------------------------------------------------
module psd_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  psd_pkg::out_item_t push_data,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output psd_pkg::out_item_t out_data
);
    import psd_pkg::*;

    out_item_t  head_reg, head_next;
    out_item_t  tail_reg, tail_next;
    logic [1:0] cnt_reg,  cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = head_reg;
    assign space     = (cnt_reg != 2'd2);
    assign pop       = out_valid & out_ready;

    // slot update for push and pop
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    head_next = push_data;
                end
                else
                begin
                    tail_next = push_data;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                head_next = tail_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

### rtl/ppm_stream_decoder_with_crop.sv
// ----------------------------------------------------------------------------
// ppm_stream_decoder_with_crop
// Binary PPM byte stream decoder with a configurable crop window.
// ----------------------------------------------------------------------------
// One stream byte is taken per clock. Each byte is decoded in the cycle it is
// accepted and its result, if any, is valid on the result channel from the
// next cycle on. A two-slot result buffer holds finished results, so input
// keeps flowing while one result waits; in_ready drops only while both slots
// are occupied. Results come out in order: a header result with the cropped
// size, the pixels inside the crop window, and a status result on any error.
// After an error or the last pixel all further input is swallowed until
// reset. The crop registers are written through the configuration channel,
// which is always ready, and should change only while the decoder is idle.
module ppm_stream_decoder_with_crop (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  psd_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output psd_pkg::out_item_t                out_data
);
    import psd_pkg::*;

    crop_t     crop;
    logic      accept;
    logic      res_valid;
    out_item_t res_data;
    logic      space;

    assign in_ready = space;
    assign accept   = in_valid & space;

    // crop window registers
    psd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .crop      (crop)
    );

    // byte decoder
    psd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .crop      (crop),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // result buffer
    psd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
